FILE: sv/deqs_pkg.sv
// ----------------------------------------------------------------------------
// deqs_pkg
// Shared types, codes and helpers for the double-ended queue with search.
// ----------------------------------------------------------------------------
package deqs_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int VALUE_W = 32;
    localparam int OP_W    = 3;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_SEARCH     = 3'd4
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic signed [VALUE_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] popped_value;
        logic                      found;
        logic [STAT_W-1:0]         status;
        logic [COUNT_W-1:0]        count;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_WAIT,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic pop_cap;
        logic scan;
        logic res_load;
    } cmd_t;

    typedef struct packed {
        logic is_pop;
        logic is_search;
        logic empty;
        logic scan_done;
    } sts_t;

    // position of the entry ofs places behind front, wrapped into the store
    function automatic logic [IDX_W-1:0] slot_at(input logic [IDX_W-1:0] front,
                                                 input logic [IDX_W-1:0] ofs);
        logic [IDX_W:0] sum;
        sum = {1'b0, front} + {1'b0, ofs};
        if (sum >= (IDX_W+1)'(DEPTH))
        begin
            sum = sum - (IDX_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

FILE: sv/deqs_ctrl.sv
// ----------------------------------------------------------------------------
// deqs_ctrl
// Sequencer: accepts one request, steps the datapath through it, then hands
// the result to the output register.
// ----------------------------------------------------------------------------
module deqs_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output deqs_pkg::cmd_t cmd,
    input  deqs_pkg::sts_t sts
);
    import deqs_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (sts.is_pop && !sts.empty)
                begin
                    state_next = S_POP_WAIT;
                end
                else if (sts.is_search && !sts.empty)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_POP_WAIT:
            begin
                cmd.pop_cap = 1'b1;
                state_next  = S_DONE;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    a_res_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending result");

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |=> (state_reg == S_IDLE && out_valid_reg))
        else $error("result load did not present output");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.exec, cmd.pop_cap, cmd.scan, cmd.res_load}))
        else $error("more than one datapath command at once");

endmodule

FILE: sv/deqs_dp.sv
// ----------------------------------------------------------------------------
// deqs_dp
// Datapath: circular entry store, front pointer, count, search index and
// result registers.
// ----------------------------------------------------------------------------
module deqs_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  deqs_pkg::in_item_t  in_item,
    output deqs_pkg::out_item_t out_item,
    input  deqs_pkg::cmd_t      cmd,
    output deqs_pkg::sts_t      sts
);
    import deqs_pkg::*;

    logic [VALUE_W-1:0] mem [DEPTH];

    logic [OP_W-1:0]    op_reg;
    logic [VALUE_W-1:0] val_reg;
    logic [VALUE_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]   front_reg;
    logic [IDX_W-1:0]   front_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   scan_idx_reg;
    logic [CNT_W-1:0]   scan_idx_next;
    logic [VALUE_W-1:0] popped_reg;
    logic [VALUE_W-1:0] popped_next;
    logic               found_reg;
    logic               found_next;
    status_t            status_reg;
    status_t            status_next;
    out_item_t          res_reg;

    logic               full;
    logic               empty;
    logic               match;
    logic [CNT_W-1:0]   cnt_dec;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign cnt_dec = count_reg - 1'b1;
    assign match   = (rd_data_reg == val_reg);

    assign sts.is_pop    = (op_reg == OP_POP_FRONT) || (op_reg == OP_POP_BACK);
    assign sts.is_search = (op_reg == OP_SEARCH);
    assign sts.empty     = empty;
    assign sts.scan_done = match || (scan_idx_reg == count_reg);

    always_comb
    begin
        front_next    = front_reg;
        count_next    = count_reg;
        scan_idx_next = scan_idx_reg;
        popped_next   = popped_reg;
        found_next    = found_reg;
        status_next   = status_reg;
        mem_we        = 1'b0;
        mem_waddr     = front_reg;
        mem_re        = 1'b0;
        mem_raddr     = front_reg;
        if (cmd.exec)
        begin
            popped_next   = '0;
            found_next    = 1'b0;
            status_next   = ST_OK;
            scan_idx_next = '0;
            case (op_reg)
                OP_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        front_next = (front_reg == '0) ? IDX_W'(DEPTH - 1)
                                                       : front_reg - 1'b1;
                        mem_we     = 1'b1;
                        mem_waddr  = front_next;
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = slot_at(front_reg, count_reg[IDX_W-1:0]);
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = front_reg;
                        front_next = slot_at(front_reg, IDX_W'(1));
                        count_next = cnt_dec;
                    end
                end
                OP_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = slot_at(front_reg, cnt_dec[IDX_W-1:0]);
                        count_next = cnt_dec;
                    end
                end
                OP_SEARCH:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        mem_re        = 1'b1;
                        mem_raddr     = front_reg;
                        scan_idx_next = CNT_W'(1);
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
        if (cmd.pop_cap)
        begin
            popped_next = rd_data_reg;
        end
        if (cmd.scan)
        begin
            if (match)
            begin
                found_next = 1'b1;
            end
            else if (scan_idx_reg < count_reg)
            begin
                mem_re        = 1'b1;
                mem_raddr     = slot_at(front_reg, scan_idx_reg[IDX_W-1:0]);
                scan_idx_next = scan_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= val_reg;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg    <= '0;
            count_reg    <= '0;
            scan_idx_reg <= '0;
        end
        else
        begin
            front_reg    <= front_next;
            count_reg    <= count_next;
            scan_idx_reg <= scan_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= in_item.op;
            val_reg <= in_item.value;
        end
        popped_reg <= popped_next;
        found_reg  <= found_next;
        status_reg <= status_next;
        if (cmd.res_load)
        begin
            res_reg.popped_value <= popped_reg;
            res_reg.found        <= found_reg;
            res_reg.status       <= status_reg;
            res_reg.count        <= COUNT_W'(count_reg);
        end
    end

    assign out_item = res_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && !full && (op_reg == OP_PUSH_FRONT || op_reg == OP_PUSH_BACK))
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push did not advance count");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |-> (scan_idx_reg <= count_reg && scan_idx_reg != '0))
        else $error("search index out of range");

endmodule

FILE: sv/double_ended_queue_with_search.sv
// ----------------------------------------------------------------------------
// double_ended_queue_with_search
// Bounded deque of signed 32-bit values with push/pop at both ends and search.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid/in_ready, in_item): one request per item, op and
//   value. out channel (out_valid/out_ready, out_item): exactly one result
//   per request, in order: popped value, found flag, status, count.
//   Requests are taken one at a time; in_ready is high only while the
//   sequencer is idle.
//   Steps per request: push and no-op or empty/full cases pass the execute
//   and done steps; a pop adds a capture step; a search scans until it has
//   compared every stored entry or finds an early match. The next request
//   is taken in the cycle after the result loads. The search compares one
//   stored entry per cycle through the single read port of the entry store.
//   A result waits in the output register while out_ready is low; the next
//   request is still accepted and worked, and holds in its last step until
//   the output register frees.
//   Reset empties the queue (count 0, front pointer 0); store contents are
//   not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module double_ended_queue_with_search (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  deqs_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output deqs_pkg::out_item_t out_item
);
    import deqs_pkg::*;

    cmd_t cmd;
    sts_t sts;

    deqs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    deqs_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .out_item (out_item),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule
